>>> hw/rtl/tspr_pkg.sv
// Shared types, constants and the master palette for the tile/sprite renderer.
`timescale 1ns / 1ps
package tspr_pkg;
  localparam int SPRITE_COUNT_DEF = 64;

  localparam logic [2:0] CMD_NT  = 3'd0;
  localparam logic [2:0] CMD_PAL = 3'd1;
  localparam logic [2:0] CMD_OAM = 3'd2;
  localparam logic [2:0] CMD_PAT = 3'd3;
  localparam logic [2:0] CMD_RND = 3'd4;

  localparam logic [9:0]  ATTR_BASE  = 10'h3C0;
  localparam logic [12:0] BG_PAT_BASE = 13'h1000;
  localparam logic [7:0]  SCREEN_ROWS = 8'd240;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic rgb_t master_rgb(input logic [5:0] c);
    rgb_t v;
    case (c)
      6'd0:  v = '{8'h46, 8'h46, 8'h46};
      6'd1:  v = '{8'h00, 8'h06, 8'h5A};
      6'd2:  v = '{8'h00, 8'h06, 8'h78};
      6'd3:  v = '{8'h02, 8'h06, 8'h73};
      6'd4:  v = '{8'h35, 8'h03, 8'h4C};
      6'd5:  v = '{8'h57, 8'h00, 8'h0E};
      6'd6:  v = '{8'h5A, 8'h00, 8'h00};
      6'd7:  v = '{8'h41, 8'h00, 8'h00};
      6'd8:  v = '{8'h12, 8'h02, 8'h00};
      6'd9:  v = '{8'h00, 8'h14, 8'h00};
      6'd10: v = '{8'h00, 8'h1E, 8'h00};
      6'd11: v = '{8'h00, 8'h1E, 8'h00};
      6'd12: v = '{8'h00, 8'h15, 8'h21};
      6'd16: v = '{8'h9D, 8'h9D, 8'h9D};
      6'd17: v = '{8'h00, 8'h4A, 8'hB9};
      6'd18: v = '{8'h05, 8'h30, 8'hE1};
      6'd19: v = '{8'h57, 8'h18, 8'hDA};
      6'd20: v = '{8'h9F, 8'h07, 8'hA7};
      6'd21: v = '{8'hCC, 8'h02, 8'h55};
      6'd22: v = '{8'hCF, 8'h0B, 8'h00};
      6'd23: v = '{8'hA4, 8'h23, 8'h00};
      6'd24: v = '{8'h5C, 8'h3F, 8'h00};
      6'd25: v = '{8'h0B, 8'h58, 8'h00};
      6'd26: v = '{8'h00, 8'h66, 8'h00};
      6'd27: v = '{8'h00, 8'h67, 8'h13};
      6'd28: v = '{8'h00, 8'h5E, 8'h6E};
      6'd32: v = '{8'hFE, 8'hFF, 8'hFF};
      6'd33: v = '{8'h1F, 8'h9E, 8'hFF};
      6'd34: v = '{8'h53, 8'h76, 8'hFF};
      6'd35: v = '{8'h98, 8'h65, 8'hFF};
      6'd36: v = '{8'hFC, 8'h67, 8'hFF};
      6'd37: v = '{8'hFF, 8'h6C, 8'hB3};
      6'd38: v = '{8'hFF, 8'h74, 8'h66};
      6'd39: v = '{8'hFF, 8'h80, 8'h14};
      6'd40: v = '{8'hC4, 8'h9A, 8'h00};
      6'd41: v = '{8'h71, 8'hB3, 8'h00};
      6'd42: v = '{8'h28, 8'hC4, 8'h21};
      6'd43: v = '{8'h00, 8'hC8, 8'h74};
      6'd44: v = '{8'h00, 8'hBF, 8'hD0};
      6'd45: v = '{8'h2B, 8'h2B, 8'h2B};
      6'd48: v = '{8'hFE, 8'hFF, 8'hFF};
      6'd49: v = '{8'h9E, 8'hD5, 8'hFF};
      6'd50: v = '{8'hAF, 8'hC0, 8'hFF};
      6'd51: v = '{8'hD0, 8'hB8, 8'hFF};
      6'd52: v = '{8'hFE, 8'hBF, 8'hFF};
      6'd53: v = '{8'hFF, 8'hC0, 8'hE0};
      6'd54: v = '{8'hFF, 8'hC3, 8'hBD};
      6'd55: v = '{8'hFF, 8'hCA, 8'h9C};
      6'd56: v = '{8'hE7, 8'hD5, 8'h8B};
      6'd57: v = '{8'hC5, 8'hDF, 8'h8E};
      6'd58: v = '{8'hA6, 8'hE6, 8'hA3};
      6'd59: v = '{8'h94, 8'hE8, 8'hC5};
      6'd60: v = '{8'h92, 8'hE4, 8'hEB};
      6'd61: v = '{8'hA7, 8'hA7, 8'hA7};
      default: v = '{8'h00, 8'h00, 8'h00};
    endcase
    return v;
  endfunction
endpackage

>>> hw/rtl/tspr_pat_mem.sv
// Pattern memory: one write port, one registered read port.
`timescale 1ns / 1ps
module tspr_pat_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [12:0] waddr,
  input  logic [7:0]  wdata,
  input  logic [12:0] raddr,
  output logic [7:0]  rdata
);
  logic [7:0] mem [8192];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/tile_sprite_pixel_renderer.sv
// Top level of the tile and sprite pixel renderer.
// Write beats (name table, palette, OAM, pattern) run back to back while the block is idle with no result held.
// A render beat for an on-screen row (py < 240) raises out_valid after five background fetch steps,
// one slot per sprite and one output load step; a render beat for any other row gives no result.
// Result sits in an output register; the next beat is taken the cycle after it is delivered.
// rst clears control state only; store contents are undefined until written.
`timescale 1ns / 1ps
module tile_sprite_pixel_renderer #(
  parameter int SPRITE_COUNT = tspr_pkg::SPRITE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [12:0] addr,
  input  logic [7:0]  data,
  input  logic [7:0]  px,
  input  logic [7:0]  py,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_x,
  output logic [7:0]  out_y,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  localparam int SW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

  // Sequencer. Each step issues one read to one store; data arrives next step.
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_NT    = 12'b000000000010,  // read name byte
    S_AT    = 12'b000000000100,  // read attribute byte, name in
    S_PLO   = 12'b000000001000,  // read bg pattern low plane, attribute in
    S_PHI   = 12'b000000010000,  // read bg pattern high, low plane in
    S_BPAL  = 12'b000000100000,  // palette lookup for background
    S_OY    = 12'b000001000000,  // sprite: read y, bg color in on first sprite
    S_OI    = 12'b000010000000,  // read tile index, y in
    S_OA    = 12'b000100000000,  // read attribute, index in
    S_OX    = 12'b001000000000,  // read x, attribute in
    S_SPAT  = 12'b010000000000,  // sprite pattern planes and palette
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;
  logic [2:0] sub;          // sub step inside S_SPAT
  logic [SW-1:0] spr;
  logic [7:0] x, y;
  logic [7:0] name, attr_b, lo, sy, sidx, sattr, sx;
  logic [5:0] colour;
  logic sp_opaque;          // current sprite covers the pixel with a nonzero color

  // Stores
  logic [7:0] nt_mem [1024];
  logic [5:0] pal_mem [32];
  logic [7:0] oam_mem [256];
  logic [9:0] nt_ra;
  logic [4:0] pal_ra;
  logic [7:0] oam_ra;
  logic [12:0] pat_ra;
  logic [7:0] nt_rd, oam_rd, pat_rd;
  logic [5:0] pal_rd;

  logic acc_in;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign acc_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (acc_in && cmd == tspr_pkg::CMD_NT) nt_mem[addr[9:0]] <= data;
    if (acc_in && cmd == tspr_pkg::CMD_PAL) pal_mem[addr[4:0]] <= data[5:0];
    if (acc_in && cmd == tspr_pkg::CMD_OAM) oam_mem[addr[7:0]] <= data;
    nt_rd  <= nt_mem[nt_ra];
    pal_rd <= pal_mem[pal_ra];
    oam_rd <= oam_mem[oam_ra];
  end

  tspr_pat_mem u_pat (
    .clk(clk), .we(acc_in && cmd == tspr_pkg::CMD_PAT), .waddr(addr), .wdata(data),
    .raddr(pat_ra), .rdata(pat_rd)
  );

  // Sprite geometry from registered fields
  logic [7:0] srow, scol, scolf;
  logic [2:0] sh_bg, sh_sp;
  logic hit;
  assign srow  = y - sy;
  assign scol  = x - sx;
  assign scolf = sattr[6] ? (8'd7 - scol) : scol;
  assign hit = (sy < tspr_pkg::SCREEN_ROWS) && (y >= sy) && (srow < 8'd8) &&
               (x != 8'd255) && (x >= sx) && (scol < 8'd8);
  assign sh_bg = 3'd7 - x[2:0];
  assign sh_sp = 3'd7 - scolf[2:0];

  logic [1:0] bgc, spc, grp;
  logic [2:0] qd;
  assign qd = {y[4], x[4], 1'b0};
  assign grp = 2'((attr_b >> qd) & 8'h3);
  assign bgc = {pat_rd[sh_bg], lo[sh_bg]};
  assign spc = {pat_rd[sh_sp], lo[sh_sp]};

  // Store addresses derived from the pixel and the current sprite
  logic [9:0]  nt_attr_addr;
  logic [12:0] bg_row_addr, sp_row_addr;
  logic [7:0]  oam_base;
  assign nt_attr_addr = tspr_pkg::ATTR_BASE + {4'd0, y[7:5], x[7:5]};
  assign bg_row_addr  = tspr_pkg::BG_PAT_BASE | {1'b0, name, 1'b0, y[2:0]};
  assign sp_row_addr  = {1'b0, sidx, srow[3:0]};
  assign oam_base     = {6'(spr), 2'd0};

  // Read address steering
  always_comb begin
    nt_ra  = {y[7:3], x[7:3]};
    pal_ra = '0;
    oam_ra = oam_base;
    pat_ra = '0;
    case (state)
      S_AT:   nt_ra = nt_attr_addr;
      S_PLO:  pat_ra = bg_row_addr;
      S_PHI:  pat_ra = bg_row_addr + 13'd8;
      S_BPAL: pal_ra = (bgc == 2'd0) ? 5'd0 : {1'b0, grp, bgc};
      S_OI:   oam_ra = oam_base + 8'd1;
      S_OA:   oam_ra = oam_base + 8'd2;
      S_OX:   oam_ra = oam_base + 8'd3;
      S_SPAT: begin
        case (sub)
          3'd0: pat_ra = sp_row_addr;
          3'd1: pat_ra = sp_row_addr + 13'd8;
          3'd2: pal_ra = {1'b1, sattr[1:0], spc};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      sub <= '0;
      spr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (acc_in && cmd == tspr_pkg::CMD_RND && py < tspr_pkg::SCREEN_ROWS) begin
            x <= px; y <= py; state <= S_NT; spr <= '0;
          end
        end
        S_NT:  state <= S_AT;
        S_AT:  begin name <= nt_rd; state <= S_PLO; end
        S_PLO: begin attr_b <= nt_rd; state <= S_PHI; end
        S_PHI: begin lo <= pat_rd; state <= S_BPAL; end
        S_BPAL: state <= S_OY;  // high plane on pat_rd; palette read issued
        S_OY:  begin
          if (spr == '0) colour <= pal_rd;
          state <= S_OI;
        end
        S_OI:  begin sy <= oam_rd; state <= S_OA; end
        S_OA:  begin sidx <= oam_rd; state <= S_OX; end
        S_OX:  begin sattr <= oam_rd; sub <= '0; state <= S_SPAT; end
        S_SPAT: begin
          case (sub)
            3'd0: begin sx <= oam_rd; sub <= 3'd1; end
            3'd1: begin lo <= pat_rd; sub <= 3'd2; end
            3'd2: begin sp_opaque <= hit && (spc != 2'd0); sub <= 3'd3; end
            default: begin
              if (sp_opaque) colour <= pal_rd;
              if (32'(spr) == SPRITE_COUNT - 1) state <= S_OUT;
              else begin spr <= spr + SW'(1); state <= S_OY; end
            end
          endcase
        end
        S_OUT: begin out_valid <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  tspr_pkg::rgb_t rgb;
  assign rgb = tspr_pkg::master_rgb(colour);
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      out_x <= x; out_y <= y;
      red <= rgb.r; green <= rgb.g; blue <= rgb.b;
    end
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accepted beat while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red)) else $error("result dropped");
  a_no_out_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE && state != S_OUT |-> !out_valid) else $error("result while busy");
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the tile and sprite pixel renderer.
`timescale 1ns / 1ps
module testbench;

  localparam int CLK_PERIOD = 20;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int RENDER_CYCLES = 6 + 8 * tspr_pkg::SPRITE_COUNT_DEF;
  // Names and sprite tiles stay small so only a few pattern rows need writing
  localparam int NAME_MAX = 3;
  localparam int SPR_IDX_MAX = 3;
  localparam int PAT_ROWS = 16 * (NAME_MAX + 1);

  // Stimulus and response wires; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = tspr_pkg::CMD_NT;
  logic [12:0] addr = '0;
  logic [7:0]  data = '0;
  logic [7:0]  px = '0;
  logic [7:0]  py = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_x, out_y, red, green, blue;

  tile_sprite_pixel_renderer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .addr(addr), .data(data), .px(px), .py(py),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .red(red), .green(green), .blue(blue)
  );

  // Expected pixel as it should leave the block
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // Shadow copies of the four stores
  logic [7:0] nt_mem  [1024];
  logic [5:0] pal_mem [32];
  logic [7:0] oam_mem [256];
  logic [7:0] pat_mem [8192];

  // Master palette, three bytes per color index
  logic [7:0] color_lut [192] = '{
    8'h46, 8'h46, 8'h46, 8'h00, 8'h06, 8'h5A, 8'h00, 8'h06, 8'h78, 8'h02, 8'h06, 8'h73,
    8'h35, 8'h03, 8'h4C, 8'h57, 8'h00, 8'h0E, 8'h5A, 8'h00, 8'h00, 8'h41, 8'h00, 8'h00,
    8'h12, 8'h02, 8'h00, 8'h00, 8'h14, 8'h00, 8'h00, 8'h1E, 8'h00, 8'h00, 8'h1E, 8'h00,
    8'h00, 8'h15, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h9D, 8'h9D, 8'h9D, 8'h00, 8'h4A, 8'hB9, 8'h05, 8'h30, 8'hE1, 8'h57, 8'h18, 8'hDA,
    8'h9F, 8'h07, 8'hA7, 8'hCC, 8'h02, 8'h55, 8'hCF, 8'h0B, 8'h00, 8'hA4, 8'h23, 8'h00,
    8'h5C, 8'h3F, 8'h00, 8'h0B, 8'h58, 8'h00, 8'h00, 8'h66, 8'h00, 8'h00, 8'h67, 8'h13,
    8'h00, 8'h5E, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hFE, 8'hFF, 8'hFF, 8'h1F, 8'h9E, 8'hFF, 8'h53, 8'h76, 8'hFF, 8'h98, 8'h65, 8'hFF,
    8'hFC, 8'h67, 8'hFF, 8'hFF, 8'h6C, 8'hB3, 8'hFF, 8'h74, 8'h66, 8'hFF, 8'h80, 8'h14,
    8'hC4, 8'h9A, 8'h00, 8'h71, 8'hB3, 8'h00, 8'h28, 8'hC4, 8'h21, 8'h00, 8'hC8, 8'h74,
    8'h00, 8'hBF, 8'hD0, 8'h2B, 8'h2B, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hFE, 8'hFF, 8'hFF, 8'h9E, 8'hD5, 8'hFF, 8'hAF, 8'hC0, 8'hFF, 8'hD0, 8'hB8, 8'hFF,
    8'hFE, 8'hBF, 8'hFF, 8'hFF, 8'hC0, 8'hE0, 8'hFF, 8'hC3, 8'hBD, 8'hFF, 8'hCA, 8'h9C,
    8'hE7, 8'hD5, 8'h8B, 8'hC5, 8'hDF, 8'h8E, 8'hA6, 8'hE6, 8'hA3, 8'h94, 8'hE8, 8'hC5,
    8'h92, 8'hE4, 8'hEB, 8'hA7, 8'hA7, 8'hA7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  pixel_t pixel_fifo [$];   // pixels accepted by the block but not yet seen
  int     errors = 0;
  int     cycles = 0;
  int     beats_sent = 0;
  int     pixels_seen = 0;
  int     sprite_hits = 0;
  int     in_idle_pct = 0;
  int     out_idle_pct = 0;
  int     hold_len = 0;     // request for a long output stall, taken by the receiver

  // Free-running clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Name table byte: tile names stay in the written pattern rows, attributes are free
  function automatic logic [7:0] nt_byte(logic [12:0] a);
    return (a[9:0] < tspr_pkg::ATTR_BASE) ? 8'($urandom_range(0, NAME_MAX)) : 8'($urandom);
  endfunction

  // OAM byte: the tile index byte stays in the written sprite pattern rows
  function automatic logic [7:0] oam_byte(logic [12:0] a);
    return (a[1:0] == 2'd1) ? 8'($urandom_range(0, SPR_IDX_MAX)) : 8'($urandom);
  endfunction

  // Pattern address: anywhere, or inside the rows that renders actually fetch
  function automatic logic [12:0] pat_addr();
    logic [12:0] a;
    case ($urandom_range(0, 2))
      0: a = 13'($urandom);
      1: a = tspr_pkg::BG_PAT_BASE | 13'($urandom_range(0, PAT_ROWS - 1));
      default: a = 13'($urandom_range(0, PAT_ROWS - 1));
    endcase
    return a;
  endfunction

  // Two-bit color number of one column of a pattern row (col 0 is leftmost)
  function automatic logic [1:0] tile_bits(logic [12:0] row_addr, logic [2:0] col);
    logic [7:0] lo, hi;
    int sh;
    lo = pat_mem[row_addr];
    hi = pat_mem[row_addr + 13'd8];
    sh = 7 - col;
    return {hi[sh], lo[sh]};
  endfunction

  // Apply one beat to the shadow stores; returns 1 when a pixel comes out
  function automatic bit shade_pixel(logic [2:0] c, logic [12:0] a, logic [7:0] d,
                                     logic [7:0] x, logic [7:0] y, output pixel_t pix);
    logic [7:0]  name, attr, sy, sidx, sattr, sx;
    logic [9:0]  tile, attr_loc;
    logic [1:0]  group, bits;
    logic [2:0]  col;
    logic [5:0]  color;
    int          quad;
    bit          hit;
    pix = '0;
    hit = 1'b0;
    case (c)
      tspr_pkg::CMD_NT:  begin nt_mem[a[9:0]] = d; return 1'b0; end
      tspr_pkg::CMD_PAL: begin pal_mem[a[4:0]] = d[5:0]; return 1'b0; end
      tspr_pkg::CMD_OAM: begin oam_mem[a[7:0]] = d; return 1'b0; end
      tspr_pkg::CMD_PAT: begin pat_mem[a] = d; return 1'b0; end
      tspr_pkg::CMD_RND: ;
      default: return 1'b0;
    endcase
    if (y >= tspr_pkg::SCREEN_ROWS) return 1'b0;

    // Background: tile, attribute quadrant, shared backdrop for color 0
    tile = {y[7:3], x[7:3]};
    name = nt_mem[tile];
    attr_loc = tspr_pkg::ATTR_BASE + {y[7:5], x[7:5]};
    attr = nt_mem[attr_loc];
    quad = (y[4] ? 4 : 0) + (x[4] ? 2 : 0);
    group = attr[quad +: 2];
    bits = tile_bits(tspr_pkg::BG_PAT_BASE + {1'b0, name, 1'b0, y[2:0]}, x[2:0]);
    color = (bits == 2'd0) ? pal_mem[0] : pal_mem[{1'b0, group, bits}];

    // Sprites: last opaque covering entry wins, column 255 never gets one
    for (int i = 0; i < tspr_pkg::SPRITE_COUNT_DEF; i++) begin
      sy    = oam_mem[i * 4];
      sidx  = oam_mem[i * 4 + 1];
      sattr = oam_mem[i * 4 + 2];
      sx    = oam_mem[i * 4 + 3];
      if (sy >= tspr_pkg::SCREEN_ROWS || y < sy || int'(y) >= int'(sy) + 8) continue;
      if (x == 8'd255 || x < sx || int'(x) >= int'(sx) + 8) continue;
      col = 3'(x - sx);
      if (sattr[6]) col = 3'd7 - col;
      bits = tile_bits({1'b0, sidx, 4'(y - sy)}, col);
      if (bits != 2'd0) begin
        color = pal_mem[{1'b1, sattr[1:0], bits}];
        hit = 1'b1;
      end
    end
    if (hit) sprite_hits++;
    pix.x = x;
    pix.y = y;
    pix.r = color_lut[color * 3];
    pix.g = color_lut[color * 3 + 1];
    pix.b = color_lut[color * 3 + 2];
    return 1'b1;
  endfunction

  // Offer one beat with random idle gaps; returns once the block takes it
  task automatic send_beat(logic [2:0] c, logic [12:0] a, logic [7:0] d,
                           logic [7:0] x, logic [7:0] y);
    pixel_t pix;
    bit     stalled;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd  <= c;
    addr <= a;
    data <= d;
    px   <= x;
    py   <= y;
    // stall is sampled mid-cycle, away from the edge that updates it
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    beats_sent++;
    if (shade_pixel(c, a, d, x, y, pix)) pixel_fifo.push_back(pix);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_cnt = hold_len;
        hold_len = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Result checker; a beat that is valid and unstalled mid-cycle moves at the next edge
  always @(negedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (pixel_fifo.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d rgb=%02h%02h%02h",
                 $time, out_x, out_y, red, green, blue);
      end else begin
        want = pixel_fifo.pop_front();
        if (out_x !== want.x) begin
          errors++;
          $display("%0t: out_x expected %0d actual %0d", $time, want.x, out_x);
        end
        if (out_y !== want.y) begin
          errors++;
          $display("%0t: out_y expected %0d actual %0d", $time, want.y, out_y);
        end
        if (red !== want.r) begin
          errors++;
          $display("%0t: red at (%0d,%0d) expected %02h actual %02h",
                   $time, want.x, want.y, want.r, red);
        end
        if (green !== want.g) begin
          errors++;
          $display("%0t: green at (%0d,%0d) expected %02h actual %02h",
                   $time, want.x, want.y, want.g, green);
        end
        if (blue !== want.b) begin
          errors++;
          $display("%0t: blue at (%0d,%0d) expected %02h actual %02h",
                   $time, want.x, want.y, want.b, blue);
        end
      end
    end
  end

  // Every entry that the background or a covering sprite reads gets written first, so no pixel uses an unknown byte
  task automatic test_fill_stores();
    for (int i = 0; i < 1024; i++)
      send_beat(tspr_pkg::CMD_NT, 13'(i), nt_byte(13'(i)), 8'd0, 8'd0);
    for (int i = 0; i < 32; i++)
      send_beat(tspr_pkg::CMD_PAL, 13'(i), 8'($urandom), 8'd0, 8'd0);
    // sprite y mostly on screen so that many sprites cover something
    for (int i = 0; i < 256; i++)
      send_beat(tspr_pkg::CMD_OAM, 13'(i),
                (i % 4 == 0) ? 8'($urandom_range(0, 250)) : oam_byte(13'(i)),
                8'd0, 8'd0);
    // sprite rows at the bottom of pattern memory, background rows from BG_PAT_BASE
    for (int i = 0; i < PAT_ROWS; i++) begin
      send_beat(tspr_pkg::CMD_PAT, 13'(i), 8'($urandom), 8'd0, 8'd0);
      send_beat(tspr_pkg::CMD_PAT, tspr_pkg::BG_PAT_BASE | 13'(i), 8'($urandom),
                8'd0, 8'd0);
    end
  endtask

  // Short hand-picked cases: overlap, flip, hidden sprites, edges, dropped beats
  task automatic test_directed();
    // addresses past the store depth wrap; palette keeps six bits
    send_beat(tspr_pkg::CMD_NT, 13'h1FFF, 8'hFF, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_PAL, 13'h1FE1, 8'hFF, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_PAL, 13'h0000, 8'h00, 8'd0, 8'd0);
    // sprites 0 and 1 on top of each other, 0 flipped; later one wins where opaque
    send_beat(tspr_pkg::CMD_OAM, 13'd0, 8'd10, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_OAM, 13'd2, 8'h42, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_OAM, 13'd3, 8'd20, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_OAM, 13'd4, 8'd10, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_OAM, 13'd7, 8'd20, 8'd0, 8'd0);
    // sprite below the screen is hidden; last sprite sits against the right edge
    send_beat(tspr_pkg::CMD_OAM, 13'd8, 8'd245, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_OAM, 13'd252, 8'd100, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_OAM, 13'hFF, 8'd250, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_PAT, 13'h1FFF, 8'hAA, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_RND, 13'd0, 8'd0, 8'd22, 8'd12);
    send_beat(tspr_pkg::CMD_RND, 13'd0, 8'd0, 8'd27, 8'd17);
    send_beat(tspr_pkg::CMD_RND, 13'd0, 8'd0, 8'd250, 8'd102);
    send_beat(tspr_pkg::CMD_RND, 13'd0, 8'd0, 8'd255, 8'd102);
    send_beat(tspr_pkg::CMD_RND, 13'd0, 8'd0, 8'd0, 8'd0);
    send_beat(tspr_pkg::CMD_RND, 13'h1FFF, 8'hFF, 8'd255, 8'd239);
    // rows off screen and unused commands produce nothing
    send_beat(tspr_pkg::CMD_RND, 13'd0, 8'd0, 8'd10, 8'd240);
    send_beat(tspr_pkg::CMD_RND, 13'd0, 8'd0, 8'd10, 8'd255);
    send_beat(3'd5, 13'd5, 8'd5, 8'd5, 8'd5);
    send_beat(3'd6, 13'd6, 8'd6, 8'd6, 8'd6);
    send_beat(3'd7, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(tspr_pkg::CMD_RND, 13'd0, 8'd0, 8'd128, 8'd128);
  endtask

  // Random mix, mostly writes and renders over all stores
  task automatic test_random_mix(int count, int in_pct, int out_pct);
    int roll;
    logic [12:0] a;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      a = 13'($urandom);
      if (roll < 12)
        send_beat(tspr_pkg::CMD_NT, a, nt_byte(a), 8'($urandom), 8'($urandom));
      else if (roll < 20)
        send_beat(tspr_pkg::CMD_PAL, a, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (roll < 35)
        send_beat(tspr_pkg::CMD_OAM, a, oam_byte(a), 8'($urandom), 8'($urandom));
      else if (roll < 55)
        send_beat(tspr_pkg::CMD_PAT, pat_addr(), 8'($urandom), 8'($urandom), 8'($urandom));
      else if (roll < 58)
        send_beat(3'($urandom_range(5, 7)), a, 8'($urandom), 8'($urandom),
                  8'($urandom));
      else if (roll < 62)
        send_beat(tspr_pkg::CMD_RND, a, 8'($urandom), 8'($urandom),
                  8'($urandom_range(240, 255)));
      else
        send_beat(tspr_pkg::CMD_RND, a, 8'($urandom), 8'($urandom),
                  8'($urandom_range(0, 239)));
    end
  endtask

  // Output held off long enough that the block backs up onto its input
  task automatic test_backpressure();
    logic [12:0] a;
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_len = 4 * RENDER_CYCLES;
    for (int n = 0; n < 6; n++) begin
      send_beat(tspr_pkg::CMD_RND, 13'd0, 8'd0, 8'($urandom), 8'($urandom_range(0, 239)));
      a = 13'($urandom);
      send_beat(tspr_pkg::CMD_OAM, a, oam_byte(a), 8'd0, 8'd0);
    end
  endtask

  task automatic drain();
    int wait_cnt;
    go_idle();
    while (pixel_fifo.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (wait_cnt < 2 * RENDER_CYCLES) begin
      @(posedge clk);
      wait_cnt++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    in_idle_pct = 22;
    out_idle_pct = 71;
    test_fill_stores();
    test_directed();
    test_random_mix(120, 22, 71);
    test_random_mix(120, 71, 22);
    test_backpressure();
    test_random_mix(120, 0, 0);
    drain();
    $display("Covered %0d beats and %0d pixels (%0d with a sprite on top),",
             beats_sent, pixels_seen, sprite_hits);
    $display("with store fills, edge cases, random idling and a long output hold-off.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tspr_pkg.sv
hw/rtl/tspr_pat_mem.sv
hw/rtl/tile_sprite_pixel_renderer.sv
tb/sv/testbench.sv
